>>> rtl/core/fsrs_pkg.sv
package fsrs_pkg;

	localparam int unsigned MaxServices = 4;
	localparam int unsigned IdW         = $clog2(MaxServices);
	localparam int unsigned SlotW       = 4;
	localparam int unsigned CntW        = IdW + 1;
	localparam int unsigned LenW        = SlotW + 1;
	localparam int unsigned AddrW       = 3;
	localparam int unsigned DataW       = 32;
	localparam int unsigned RegSelBit   = 2;

	localparam logic [LenW-1:0] GroupLen      = LenW'(5);
	localparam logic [LenW-1:0] ThreeAudioLen = LenW'(7);
	localparam logic [LenW-1:0] GroupLen2     = LenW'(10);
	localparam logic [LenW-1:0] GroupLen3     = LenW'(15);

	typedef enum logic {
		REG_ACTIVE_MASK    = 1'b0,
		REG_DATA_FLAG_MASK = 1'b1
	} fsrs_reg_t;

	typedef struct packed {
		logic [MaxServices-1:0] active_mask;
		logic [MaxServices-1:0] data_flag_mask;
	} fsrs_cfg_t;

	typedef struct packed {
		logic [IdW-1:0]   short_id;
		logic [SlotW-1:0] slot;
		logic             last_of_cycle;
		logic             no_service;
	} fsrs_result_t;

	// number of set bits in a service mask
	function automatic logic [CntW-1:0] count_set(input logic [MaxServices-1:0] mask);
		logic [CntW-1:0] cnt;
		cnt = '0;
		for (int n = 0; n < MaxServices; n++) begin
			cnt = cnt + CntW'(mask[n]);
		end
		return cnt;
	endfunction

	// short id of the k-th set bit, counting from the lowest
	function automatic logic [IdW-1:0] kth_set(input logic [MaxServices-1:0] mask,
			input logic [IdW-1:0] k);
		logic [CntW-1:0] cnt;
		logic [IdW-1:0]  id;
		cnt = '0;
		id  = '0;
		for (int n = 0; n < MaxServices; n++) begin
			if (mask[n]) begin
				if (cnt == {1'b0, k}) begin
					id = IdW'(n);
				end
				cnt = cnt + CntW'(1);
			end
		end
		return id;
	endfunction

endpackage

>>> rtl/core/fsrs_in_if.sv
interface fsrs_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

>>> rtl/core/fsrs_out_if.sv
interface fsrs_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] short_id;
	logic [3:0] slot;
	logic       last_of_cycle;
	logic       no_service;

	modport source (output valid, output short_id, output slot, output last_of_cycle,
		output no_service, input ready);
	modport sink (input valid, input short_id, input slot, input last_of_cycle,
		input no_service, output ready);
endinterface

>>> rtl/core/fsrs_apb_regs.sv
module fsrs_apb_regs
	import fsrs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output fsrs_cfg_t        cfg
);

	fsrs_cfg_t cfg_q;
	fsrs_reg_t sel;
	logic      wr_en;

	assign sel    = fsrs_reg_t'(paddr[RegSelBit]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_mask    <= MaxServices'(1);
			cfg_q.data_flag_mask <= '0;
		end else if (wr_en) begin
			unique case (sel)
				REG_ACTIVE_MASK:    cfg_q.active_mask    <= pwdata[MaxServices-1:0];
				REG_DATA_FLAG_MASK: cfg_q.data_flag_mask <= pwdata[MaxServices-1:0];
				default:            cfg_q.active_mask    <= cfg_q.active_mask;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (sel)
			REG_ACTIVE_MASK:    prdata[MaxServices-1:0] = cfg_q.active_mask;
			REG_DATA_FLAG_MASK: prdata[MaxServices-1:0] = cfg_q.data_flag_mask;
			default:            prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/fsrs_slot_seq.sv
module fsrs_slot_seq
	import fsrs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  fsrs_cfg_t    cfg,
	input  logic         restart,
	input  logic         advance,
	output fsrs_result_t result
);

	logic [SlotW-1:0]       cnt_q;
	logic [MaxServices-1:0] audio_mask;
	logic [MaxServices-1:0] data_mask;
	logic [CntW-1:0]        na;
	logic [CntW-1:0]        nd;
	logic [LenW-1:0]        len;
	logic [SlotW-1:0]       cur;
	logic [SlotW-1:0]       s;
	logic [LenW-1:0]        s_inc;
	logic [SlotW-1:0]       mod3;
	logic [SlotW-1:0]       grp;
	logic [SlotW-1:0]       pos;
	logic [IdW-1:0]         id;
	logic [SlotW-1:0]       cnt_next;

	assign audio_mask = cfg.active_mask & ~cfg.data_flag_mask;
	assign data_mask  = cfg.active_mask & cfg.data_flag_mask;
	assign na         = count_set(audio_mask);
	assign nd         = count_set(data_mask);

	always_comb begin
		if (na == '0 || nd == '0) begin
			len = LenW'(na) + LenW'(nd);
		end else if (na >= CntW'(3)) begin
			len = ThreeAudioLen;
		end else begin
			case (nd)
				CntW'(1): len = GroupLen;
				CntW'(2): len = GroupLen2;
				default:  len = GroupLen3;
			endcase
		end
	end

	// a counter left beyond the pattern after a reconfiguration falls back to slot 0
	assign cur   = restart ? '0 : cnt_q;
	assign s     = ({1'b0, cur} >= len) ? '0 : cur;
	assign s_inc = {1'b0, s} + LenW'(1);

	// slot within a three-audio group and within a five-slot group
	assign mod3 = (s >= SlotW'(3)) ? s - SlotW'(3) : s;
	assign grp  = (s >= SlotW'(10)) ? SlotW'(2) : ((s >= SlotW'(5)) ? SlotW'(1) : '0);
	assign pos  = s - SlotW'(5) * grp;

	always_comb begin
		if (nd == '0) begin
			id = kth_set(audio_mask, s[IdW-1:0]);
		end else if (na == '0) begin
			id = kth_set(data_mask, s[IdW-1:0]);
		end else if (na >= CntW'(3)) begin
			id = (s < SlotW'(6)) ? kth_set(audio_mask, mod3[IdW-1:0])
				: kth_set(data_mask, '0);
		end else if (pos < SlotW'(4)) begin
			id = (na == CntW'(1)) ? kth_set(audio_mask, '0)
				: kth_set(audio_mask, {{(IdW-1){1'b0}}, pos[0]});
		end else begin
			id = kth_set(data_mask, grp[IdW-1:0]);
		end
	end

	always_comb begin
		if (len == '0) begin
			result.short_id      = '0;
			result.slot          = '0;
			result.last_of_cycle = 1'b0;
			result.no_service    = 1'b1;
			cnt_next             = '0;
		end else begin
			result.short_id      = id;
			result.slot          = s;
			result.last_of_cycle = (s_inc == len);
			result.no_service    = 1'b0;
			cnt_next             = (s_inc >= len) ? '0 : s_inc[SlotW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= cnt_next;
		end
	end

	a_no_service_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.no_service |-> (result.short_id == '0 && result.slot == '0
			&& !result.last_of_cycle))
		else $error("no_service with non-zero fields");

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (result.last_of_cycle || result.no_service)) |=> (cnt_q == '0))
		else $error("slot counter did not wrap");

	a_step_on: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !result.last_of_cycle && !result.no_service)
			|=> (cnt_q == $past(result.slot) + SlotW'(1)))
		else $error("slot counter did not step");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!result.no_service |-> ({1'b0, result.slot} < len))
		else $error("slot beyond pattern length");

endmodule

>>> rtl/core/fac_service_repetition_sequencer_core.sv
// channel | dir | handshake        | payload
// req     | in  | valid/ready      | restart
// res     | out | valid/ready      | short_id, slot, last_of_cycle, no_service
// apb     | in  | psel/penable     | paddr[2:0], pwdata/prdata 32 bits, pready tied high
//
// one request per cycle sustained while res is ready; a request is held in the input
// register, its result then in the result register that drives res; the slot counter
// steps as a request leaves the input register; the result register parts the sides,
// so a stalled res only holds back req once both stages are full
// arst_n clears the slot counter, valid flags and loads active_mask 1, data_flag_mask 0
module fac_service_repetition_sequencer_core
	import fsrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	fsrs_in_if.sink           req,
	fsrs_out_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [AddrW-1:0]  paddr,
	input  logic [DataW-1:0]  pwdata,
	output logic [DataW-1:0]  prdata,
	output logic              pready
);

	fsrs_cfg_t    cfg;
	fsrs_result_t result;
	fsrs_result_t result_s2;
	logic         valid_s1;
	logic         restart_s1;
	logic         valid_s2;
	logic         adv_s1;

	fsrs_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fsrs_slot_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart_s1),
		.advance (adv_s1),
		.result  (result)
	);

	assign adv_s1    = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			restart_s1 <= req.restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign res.valid         = valid_s2;
	assign res.short_id      = result_s2.short_id;
	assign res.slot          = result_s2.slot;
	assign res.last_of_cycle = result_s2.last_of_cycle;
	assign res.no_service    = result_s2.no_service;

endmodule

>>> tb/fac_service_repetition_sequencer_core_tb.sv
module fac_service_repetition_sequencer_core_tb;
	import fsrs_pkg::*;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned LongHold   = 80;
	localparam int unsigned Phases     = 14;
	localparam int unsigned PhaseItems = 32;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	fsrs_in_if  req_if ();
	fsrs_out_if res_if ();

	fac_service_repetition_sequencer_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow registers and slot counter of the sequencer
	logic [MaxServices-1:0] active_sh;
	logic [MaxServices-1:0] data_sh;
	int unsigned            next_slot;

	logic         restart_q[$];
	fsrs_result_t fac_expect_q[$];

	bit           idle_on;
	int unsigned  src_gap;
	int unsigned  sink_gap;
	int unsigned  stall_left;
	int unsigned  mismatches;
	int unsigned  cycles;
	fsrs_result_t got;
	fsrs_result_t want;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch: %s", msg);
		end
	endtask

	// service signalled for one fac block, steps the shadow slot counter
	function automatic fsrs_result_t pick_service(input logic restart);
		logic [IdW-1:0] aud [MaxServices];
		logic [IdW-1:0] dat [MaxServices];
		int unsigned    na;
		int unsigned    nd;
		int unsigned    len;
		int unsigned    s;
		int unsigned    pos;
		fsrs_result_t   r;
		na = 0;
		nd = 0;
		r  = '0;
		for (int n = 0; n < MaxServices; n++) begin
			aud[n] = '0;
			dat[n] = '0;
		end
		for (int n = 0; n < MaxServices; n++) begin
			if (active_sh[n]) begin
				if (data_sh[n]) begin
					dat[nd] = IdW'(n);
					nd++;
				end else begin
					aud[na] = IdW'(n);
					na++;
				end
			end
		end
		if (na == 0 || nd == 0) len = na + nd;
		else if (na >= 3) len = ThreeAudioLen;
		else len = GroupLen * nd;
		if (restart) next_slot = 0;
		if (len == 0) begin
			next_slot    = 0;
			r.no_service = 1'b1;
			return r;
		end
		s = next_slot;
		// counter left over from a longer pattern
		if (s >= len) s = 0;
		if (nd == 0) r.short_id = aud[s % MaxServices];
		else if (na == 0) r.short_id = dat[s % MaxServices];
		else if (na >= 3) r.short_id = (s < 6) ? aud[s % 3] : dat[0];
		else begin
			pos = s % GroupLen;
			if (pos < GroupLen - 1) r.short_id = (na == 1) ? aud[0] : aud[pos & 1];
			else r.short_id = dat[(s / GroupLen) % MaxServices];
		end
		r.slot          = SlotW'(s);
		r.last_of_cycle = (s + 1 == len);
		next_slot       = (s + 1 >= len) ? 0 : s + 1;
		return r;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid   <= 1'b0;
			req_if.restart <= 1'b0;
			src_gap = 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				fac_expect_q = {fac_expect_q, pick_service(req_if.restart)};
			end
			if (!req_if.valid || req_if.ready) begin
				if (src_gap != 0) begin
					src_gap--;
					req_if.valid <= 1'b0;
				end else if (restart_q.size() == 0) begin
					req_if.valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(0, 6);
					req_if.valid <= 1'b0;
				end else begin
					req_if.valid   <= 1'b1;
					req_if.restart <= restart_q.pop_front();
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got = {res_if.short_id, res_if.slot, res_if.last_of_cycle, res_if.no_service};
				if (fac_expect_q.size() == 0) begin
					flag($sformatf("result with none pending: id %0d slot %0d last %0b none %0b",
						got.short_id, got.slot, got.last_of_cycle, got.no_service));
				end else begin
					want = fac_expect_q.pop_front();
					if (got.short_id !== want.short_id || got.slot !== want.slot ||
							got.last_of_cycle !== want.last_of_cycle ||
							got.no_service !== want.no_service) begin
						flag($sformatf({"expected id %0d slot %0d last %0b none %0b, ",
							"got id %0d slot %0d last %0b none %0b"},
							want.short_id, want.slot, want.last_of_cycle, want.no_service,
							got.short_id, got.slot, got.last_of_cycle, got.no_service));
					end
				end
			end
			if (sink_gap != 0) begin
				sink_gap--;
				res_if.ready <= 1'b0;
			end else if (stall_left != 0) begin
				res_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(0, 6);
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	task automatic reg_write(input fsrs_reg_t r, input logic [MaxServices-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrW'({r, 2'b00});
		pwdata  <= DataW'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		if (r == REG_ACTIVE_MASK) active_sh = v;
		else data_sh = v;
		// read back through the same port
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== DataW'(v)) begin
			flag($sformatf("register %s read %0h, written %0h", r.name(), prdata, v));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_services(input logic [MaxServices-1:0] act,
			input logic [MaxServices-1:0] dflag);
		reg_write(REG_ACTIVE_MASK, act);
		reg_write(REG_DATA_FLAG_MASK, dflag);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (restart_q.size() != 0 || req_if.valid || fac_expect_q.size() != 0);
	endtask

	// restart bits taken lowest first
	task automatic play(input logic [7:0] restarts, input int unsigned n);
		for (int i = 0; i < n; i++) begin
			restart_q = {restart_q, restarts[i]};
		end
		drain();
	endtask

	task automatic feed(input int unsigned n, input int unsigned restart_odds);
		for (int i = 0; i < n; i++) begin
			restart_q = {restart_q, logic'($urandom_range(1, restart_odds) == 1)};
		end
		drain();
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_if.valid   = 1'b0;
		req_if.restart = 1'b0;
		res_if.ready   = 1'b0;
		active_sh      = 4'b0001;
		data_sh        = 4'b0000;
		next_slot      = 0;
		idle_on        = 1'b1;
		stall_left     = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: one audio service
		play(8'b0000_0000, 2);
		// nothing active
		set_services(4'b0000, 4'b0000);
		play(8'b0000_0001, 2);
		// four audio in turn, restart mid-sequence
		set_services(4'b1111, 4'b0000);
		play(8'b0000_0100, 4);
		set_services(4'b1111, 4'b1111);
		play(8'b0000_0000, 2);
		// three audio and one data, then a shorter pattern with the counter past its end
		set_services(4'b1111, 4'b0100);
		play(8'b0000_0000, 6);
		set_services(4'b0011, 4'b0000);
		play(8'b0000_0000, 2);
		// data flags on inactive services
		set_services(4'b0001, 4'b1110);
		play(8'b0000_0000, 2);

		for (int p = 0; p < Phases; p++) begin
			set_services($urandom_range(0, 15), $urandom_range(0, 15));
			if (p == 3) stall_left <= LongHold;
			idle_on = (p != Phases - 1);
			feed(PhaseItems, 12);
		end

		repeat (8) @(posedge clk);
		if (fac_expect_q.size() != 0) begin
			flag($sformatf("%0d results never arrived", fac_expect_q.size()));
		end
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
